// ===== sv/ipacl_pkg.sv =====
// ----------------------------------------------------------------------------
// ipacl_pkg
// Shared types and constants for the IPv4 first-match access-control block:
// rule entry layout, controller states and the controller/datapath signals.
// ----------------------------------------------------------------------------
package ipacl_pkg;

  localparam int RULE_ENTRIES_DEF = 16;
  localparam int HIT_W            = 4;
  localparam int SLOT_W           = 4;
  localparam int ADDR_W           = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              deny;
  } rule_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input item, clear result, restart scan
    logic write;      // store the captured rule
    logic scan_step;  // read one rule slot and check the previous one
    logic out_load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lookup;     // the offered item is a lookup
    logic match;      // the checked slot matched
    logic last;       // the checked slot is the final one
    logic out_free;   // the output register takes a result this cycle
  } stat_t;

endpackage

// ===== sv/ip_acl_first_match.sv =====
// ----------------------------------------------------------------------------
// ip_acl_first_match
// First-match IPv4 access-control classifier over an ordered rule table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one item per transfer.
//   func 0 stores entry_address, entry_mask and entry_deny in slot
//   entry_index and sets its valid bit to entry_enable; slots at or beyond
//   RULE_ENTRIES are left alone. func 1 classifies query_address: the
//   lowest valid slot with (query_address & mask) == address gives deny and
//   hit_index; with no match the verdict is allow with hit and hit_index 0.
//   Every item yields exactly one transfer on the output channel
//   (out_valid / out_stall); write items return all zeros.
//   A write passes through S_WRITE and S_FINISH to the output register; a
//   lookup scans the slots in order from slot 0 and stops at the first
//   match or the last slot. The rule memory is read one slot per cycle,
//   and the block takes no new item until the current one is finished.
//   The next item is taken while a finished result waits in the output
//   register; a stalled receiver holds the result and, once the following
//   item is done, stalls the input channel.
//   Reset clears all valid bits, the controller and the output valid.
// ----------------------------------------------------------------------------
module ip_acl_first_match #(
  parameter int RULE_ENTRIES = ipacl_pkg::RULE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [ipacl_pkg::SLOT_W-1:0] entry_index,
  input  logic [ipacl_pkg::ADDR_W-1:0] entry_address,
  input  logic [ipacl_pkg::ADDR_W-1:0] entry_mask,
  input  logic                         entry_deny,
  input  logic                         entry_enable,
  input  logic [ipacl_pkg::ADDR_W-1:0] query_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         deny,
  output logic                         hit,
  output logic [ipacl_pkg::HIT_W-1:0]  hit_index
);
  import ipacl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ipacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipacl_dp #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .entry_index   (entry_index),
    .entry_address (entry_address),
    .entry_mask    (entry_mask),
    .entry_deny    (entry_deny),
    .entry_enable  (entry_enable),
    .query_address (query_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .deny          (deny),
    .hit           (hit),
    .hit_index     (hit_index)
  );

endmodule

// ===== sv/ipacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipacl_ctrl
// Sequencer for the rule table: takes one item at a time, runs a write or a
// slot-by-slot scan in the datapath, then hands the result to the output.
// ----------------------------------------------------------------------------
module ipacl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ipacl_pkg::stat_t stat,
  output ipacl_pkg::cmd_t  cmd
);
  import ipacl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.lookup ? S_SCAN : S_WRITE;
        end
      end
      S_WRITE: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.match || stat.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/ipacl_dp.sv =====
// ----------------------------------------------------------------------------
// ipacl_dp
// Rule memory, valid bits, scan pointer, match compare and output register.
// The memory is read one slot per cycle with registered read data.
// ----------------------------------------------------------------------------
module ipacl_dp #(
  parameter int RULE_ENTRIES = ipacl_pkg::RULE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ipacl_pkg::cmd_t              cmd,
  output ipacl_pkg::stat_t             stat,
  input  logic                         func,
  input  logic [ipacl_pkg::SLOT_W-1:0] entry_index,
  input  logic [ipacl_pkg::ADDR_W-1:0] entry_address,
  input  logic [ipacl_pkg::ADDR_W-1:0] entry_mask,
  input  logic                         entry_deny,
  input  logic                         entry_enable,
  input  logic [ipacl_pkg::ADDR_W-1:0] query_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         deny,
  output logic                         hit,
  output logic [ipacl_pkg::HIT_W-1:0]  hit_index
);
  import ipacl_pkg::*;

  localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_ENTRIES - 1);

  // captured item
  logic [SLOT_W-1:0] it_index;
  logic [ADDR_W-1:0] it_address;
  logic [ADDR_W-1:0] it_mask;
  logic              it_deny;
  logic              it_enable;
  logic [ADDR_W-1:0] it_query;

  rule_t             mem [RULE_ENTRIES];
  logic [RULE_ENTRIES-1:0] valid;

  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  rule_t             rd_data;

  logic              res_deny;
  logic              res_hit;
  logic [HIT_W-1:0]  res_idx;

  logic [EXT_W-1:0]  wr_ext;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_in_range;
  logic [EXT_W-1:0]  hit_ext;
  logic              match;

  assign wr_ext      = EXT_W'(it_index);
  assign wr_addr     = wr_ext[IDX_W-1:0];
  assign wr_in_range = (32'(it_index) < RULE_ENTRIES);
  assign hit_ext     = EXT_W'(rd_idx);

  assign match = cmd.scan_step && rd_vld && valid[rd_idx] &&
                 (rd_data.addr == (it_query & rd_data.mask));

  assign stat.lookup   = (func == FUNC_LOOKUP);
  assign stat.match    = match;
  assign stat.last     = cmd.scan_step && rd_vld && (rd_idx == LAST_IDX);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_index   <= entry_index;
      it_address <= entry_address;
      it_mask    <= entry_mask;
      it_deny    <= entry_deny;
      it_enable  <= entry_enable;
      it_query   <= query_address;
    end
  end

  // rule memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write && wr_in_range) begin
      mem[wr_addr] <= '{addr: it_address, mask: it_mask, deny: it_deny};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write && wr_in_range) begin
      valid[wr_addr] <= it_enable;
    end
  end

  // scan pointer runs one slot ahead of the compare; hold at the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
      rd_idx <= '0;
    end else if (cmd.load) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_vld <= 1'b1;
      rd_idx <= ptr;
      if (ptr != LAST_IDX) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_deny <= 1'b0;
      res_hit  <= 1'b0;
      res_idx  <= '0;
    end else if (match) begin
      res_deny <= rd_data.deny;
      res_hit  <= 1'b1;
      res_idx  <= hit_ext[HIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      deny      <= res_deny;
      hit       <= res_hit;
      hit_index <= res_idx;
    end
  end

endmodule

// ===== sim/ip_acl_first_match_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_acl_first_match_tb
// Self-checking bench for the first-match IPv4 access-control classifier.
// Sends rule writes and address lookups with random input gaps and output
// stalls. It keeps its own copy of the rule table to work out every verdict,
// and checks each result transfer, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module ip_acl_first_match_tb;
  import ipacl_pkg::*;

  localparam int SLOTS       = RULE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              act;
    logic              en;
    logic [ADDR_W-1:0] query;
  } acl_item_t;

  typedef struct {
    logic             deny;
    logic             hit;
    logic [HIT_W-1:0] index;
  } verdict_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              func;
  logic [SLOT_W-1:0] entry_index;
  logic [ADDR_W-1:0] entry_address;
  logic [ADDR_W-1:0] entry_mask;
  logic              entry_deny;
  logic              entry_enable;
  logic [ADDR_W-1:0] query_address;
  logic              out_valid;
  logic              out_stall;
  logic              deny;
  logic              hit;
  logic [HIT_W-1:0]  hit_index;

  ip_acl_first_match DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .entry_index   (entry_index),
    .entry_address (entry_address),
    .entry_mask    (entry_mask),
    .entry_deny    (entry_deny),
    .entry_enable  (entry_enable),
    .query_address (query_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .deny          (deny),
    .hit           (hit),
    .hit_index     (hit_index)
  );

  // local copy of the rule table
  logic [ADDR_W-1:0] rule_addr [SLOTS] = '{default: '0};
  logic [ADDR_W-1:0] rule_mask [SLOTS] = '{default: '0};
  bit                rule_act  [SLOTS] = '{default: 1'b0};
  bit                rule_on   [SLOTS] = '{default: 1'b0};

  verdict_t verdict_q[$];
  int       mismatches = 0;
  int       cycles     = 0;
  int       stall_left = 0;
  int       long_hold  = 0;
  bit       tx_idle_on = 1'b0;
  bit       rx_idle_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly zero, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : ~32'h0 << (32 - len);
  endfunction

  // Apply one item to the table copy and return the verdict it produces.
  function automatic verdict_t classify(acl_item_t it);
    verdict_t v;
    bit       found;
    v     = '{deny: 1'b0, hit: 1'b0, index: '0};
    found = 1'b0;
    if (it.func == FUNC_WRITE) begin
      if (it.slot < SLOTS) begin
        rule_addr[it.slot] = it.addr;
        rule_mask[it.slot] = it.mask;
        rule_act[it.slot]  = it.act;
        rule_on[it.slot]   = it.en;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && rule_on[i] && rule_addr[i] == (it.query & rule_mask[i])) begin
          found   = 1'b1;
          v.deny  = rule_act[i];
          v.hit   = 1'b1;
          v.index = HIT_W'(i);
        end
      end
    end
    return v;
  endfunction

  function automatic acl_item_t rule_write(int slot, logic [ADDR_W-1:0] addr,
                                           logic [ADDR_W-1:0] mask, logic act,
                                           logic en);
    acl_item_t it;
    it.func  = FUNC_WRITE;
    it.slot  = SLOT_W'(slot);
    it.addr  = addr;
    it.mask  = mask;
    it.act   = act;
    it.en    = en;
    it.query = $urandom();
    return it;
  endfunction

  function automatic acl_item_t addr_lookup(logic [ADDR_W-1:0] query);
    acl_item_t it;
    it.func  = FUNC_LOOKUP;
    it.slot  = SLOT_W'($urandom_range(0, SLOTS - 1));
    it.addr  = $urandom();
    it.mask  = $urandom();
    it.act   = 1'($urandom_range(0, 1));
    it.en    = 1'($urandom_range(0, 1));
    it.query = query;
    return it;
  endfunction

  // Aim most queries into the prefix of some stored rule.
  function automatic logic [ADDR_W-1:0] near_query();
    int                s;
    logic [ADDR_W-1:0] q;
    s = $urandom_range(0, SLOTS - 1);
    q = $urandom();
    if ($urandom_range(0, 9) < 7) q = rule_addr[s] | (q & ~rule_mask[s]);
    return q;
  endfunction

  function automatic acl_item_t random_item();
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 3) != 0) return addr_lookup(near_query());
    m = ($urandom_range(0, 4) == 0) ? $urandom() : prefix_mask($urandom_range(0, 32));
    a = $urandom();
    // keep the address inside its mask most of the time so the rule can hit
    if ($urandom_range(0, 7) != 0) a = a & m;
    return rule_write($urandom_range(0, SLOTS - 1), a, m, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 5) != 0);
  endfunction

  task automatic send_item(acl_item_t it);
    int gap;
    func          <= it.func;
    entry_index   <= it.slot;
    entry_address <= it.addr;
    entry_mask    <= it.mask;
    entry_deny    <= it.act;
    entry_enable  <= it.en;
    query_address <= it.query;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    verdict_q.push_back(classify(it));
    gap = tx_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = rx_idle_on ? idle_len() : 0;
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result expected none actual deny %b hit %b hit_index %0d",
                 $time, deny, hit, hit_index);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (deny !== want.deny) begin
          $display("%0t: deny expected %b actual %b", $time, want.deny, deny);
          mismatches++;
        end
        if (hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
          mismatches++;
        end
        if (hit_index !== want.index) begin
          $display("%0t: hit_index expected %0d actual %0d", $time, want.index, hit_index);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // park every slot disabled, field extremes alternating
    for (int i = 0; i < SLOTS; i++)
      send_item(rule_write(i, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1, 1'(i % 2), 1'b0));
    send_item(addr_lookup('1));
    // catch-all deny in the last slot
    send_item(rule_write(SLOTS - 1, '0, '0, 1'b1, 1'b1));
    send_item(addr_lookup(32'h0B00_0000));
    // exact host rule in slot 0
    send_item(rule_write(0, '1, '1, 1'b0, 1'b1));
    send_item(addr_lookup('1));
    send_item(rule_write(3, 32'h0A00_0000, prefix_mask(8), 1'b1, 1'b1));
    send_item(addr_lookup(32'h0A01_0203));
    // a narrower rule in a lower slot wins
    send_item(rule_write(2, 32'h0A01_0000, prefix_mask(16), 1'b0, 1'b1));
    send_item(addr_lookup(32'h0A01_0203));
    // address bits outside the mask: this rule never matches
    send_item(rule_write(1, 32'h0A00_00FF, prefix_mask(8), 1'b0, 1'b1));
    send_item(addr_lookup(32'h0A00_00FF));
    // removing a rule keeps its fields but drops it from the scan
    send_item(rule_write(2, 32'h0A01_0000, prefix_mask(16), 1'b0, 1'b0));
    send_item(addr_lookup(32'h0A01_0203));
    send_item(rule_write(SLOTS - 1, '0, '0, 1'b1, 1'b0));
    send_item(addr_lookup(32'h0B00_0000));
    drain_results();
  endtask

  task automatic test_random(int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (count) send_item(random_item());
    drain_results();
  endtask

  // Hold the output for a long stretch while lookups keep coming.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold  = 300;
    repeat (40) send_item(addr_lookup(near_query()));
    drain_results();
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_burst();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (80) send_item(random_item());
    drain_results();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    func          = FUNC_WRITE;
    entry_index   = '0;
    entry_address = '0;
    entry_mask    = '0;
    entry_deny    = 1'b0;
    entry_enable  = 1'b0;
    query_address = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(550);
    test_backpressure();
    test_burst();
    test_random(550);
    // watch for stray results after the last one
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
